FILE: hdl/obstacle_steer_speed_ramp_top_defines.svh
// Assertion macros for the obstacle steering ramp block.
// OSR_ASSERT_NOW checks the consequent in the same cycle,
// OSR_ASSERT_NEXT checks it in the following cycle.
`ifndef OBSTACLE_STEER_SPEED_RAMP_TOP_DEFINES_SVH
`define OBSTACLE_STEER_SPEED_RAMP_TOP_DEFINES_SVH

`ifndef SYNTH
`define OSR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("osr assertion failed");
`define OSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("osr assertion failed");
`else
`define OSR_ASSERT_NOW(label, clk, rst, ante, cons)
`define OSR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: hdl/osr_pkg.sv
package osr_pkg;

   localparam int DIST_W  = 12;
   localparam int FRONT_W = 13;
   localparam int SIDE_W  = 12;
   localparam int FREQ_W  = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [FRONT_W-1:0] FRONT_CLEAR_RST = 13'd400;
   localparam logic [SIDE_W-1:0]  SIDE_DIFF_RST   = 12'd10;
   localparam logic [FREQ_W-1:0]  FWD_MIN_RST     = 16'd100;
   localparam logic [FREQ_W-1:0]  FWD_MAX_RST     = 16'd1000;
   localparam logic [FREQ_W-1:0]  FWD_STEP_RST    = 16'd40;
   localparam logic [FREQ_W-1:0]  TURN_MIN_RST    = 16'd100;
   localparam logic [FREQ_W-1:0]  TURN_MAX_RST    = 16'd300;
   localparam logic [FREQ_W-1:0]  TURN_STEP_RST   = 16'd10;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRONT_CLEAR = 3'd0,
      REG_SIDE_DIFF   = 3'd1,
      REG_FWD_MIN     = 3'd2,
      REG_FWD_MAX     = 3'd3,
      REG_FWD_STEP    = 3'd4,
      REG_TURN_MIN    = 3'd5,
      REG_TURN_MAX    = 3'd6,
      REG_TURN_STEP   = 3'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_FWD   = 3'd1,
      MODE_LEFT  = 3'd2,
      MODE_RIGHT = 3'd3,
      MODE_BACK  = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      DRIVE_FWD   = 2'd0,
      DRIVE_LEFT  = 2'd1,
      DRIVE_RIGHT = 2'd2,
      DRIVE_BACK  = 2'd3
   } drive_type;

   typedef enum logic [1:0] {
      ACT_CHANGED = 2'd0,
      ACT_ACCEL   = 2'd1,
      ACT_HELD    = 2'd2
   } action_type;

   typedef struct packed {
      logic [FRONT_W-1:0] front_clear_limit;
      logic [SIDE_W-1:0]  side_diff_limit;
      logic [FREQ_W-1:0]  fwd_base_freq;
      logic [FREQ_W-1:0]  fwd_freq_limit;
      logic [FREQ_W-1:0]  fwd_step;
      logic [FREQ_W-1:0]  turn_base_freq;
      logic [FREQ_W-1:0]  turn_freq_limit;
      logic [FREQ_W-1:0]  turn_step;
   } cfg_type;

   typedef struct packed {
      logic [DIST_W-1:0] dist_right;
      logic [DIST_W-1:0] dist_right_front;
      logic [DIST_W-1:0] dist_left_front;
      logic [DIST_W-1:0] dist_left;
   } dist_type;

   typedef struct packed {
      drive_type         drive_mode;
      logic [FREQ_W-1:0] step_freq;
      action_type        action;
   } result_type;

endpackage

FILE: hdl/osr_csr.sv
module osr_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [osr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [osr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output osr_pkg::cfg_type                   cfg
);

   osr_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.front_clear_limit <= osr_pkg::FRONT_CLEAR_RST;
         cfg_ff.side_diff_limit   <= osr_pkg::SIDE_DIFF_RST;
         cfg_ff.fwd_base_freq     <= osr_pkg::FWD_MIN_RST;
         cfg_ff.fwd_freq_limit    <= osr_pkg::FWD_MAX_RST;
         cfg_ff.fwd_step          <= osr_pkg::FWD_STEP_RST;
         cfg_ff.turn_base_freq    <= osr_pkg::TURN_MIN_RST;
         cfg_ff.turn_freq_limit   <= osr_pkg::TURN_MAX_RST;
         cfg_ff.turn_step         <= osr_pkg::TURN_STEP_RST;
      end else if (csr_valid && csr_ready) begin
         case (osr_pkg::reg_index_type'(csr_index))
            osr_pkg::REG_FRONT_CLEAR:
               cfg_ff.front_clear_limit <= csr_wdata[osr_pkg::FRONT_W-1:0];
            osr_pkg::REG_SIDE_DIFF:
               cfg_ff.side_diff_limit <= csr_wdata[osr_pkg::SIDE_W-1:0];
            osr_pkg::REG_FWD_MIN:   cfg_ff.fwd_base_freq   <= csr_wdata;
            osr_pkg::REG_FWD_MAX:   cfg_ff.fwd_freq_limit  <= csr_wdata;
            osr_pkg::REG_FWD_STEP:  cfg_ff.fwd_step        <= csr_wdata;
            osr_pkg::REG_TURN_MIN:  cfg_ff.turn_base_freq  <= csr_wdata;
            osr_pkg::REG_TURN_MAX:  cfg_ff.turn_freq_limit <= csr_wdata;
            osr_pkg::REG_TURN_STEP: cfg_ff.turn_step       <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

FILE: hdl/osr_core.sv
module osr_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  osr_pkg::cfg_type     cfg,
   input  osr_pkg::dist_type    sensor,
   output osr_pkg::result_type  result
);

   osr_pkg::mode_type             mode_ff, mode_in;
   logic [osr_pkg::FREQ_W-1:0]    freq_ff, freq_in;

   logic [osr_pkg::FRONT_W-1:0]   front_sum;
   logic [osr_pkg::DIST_W:0]      left_bound, right_bound;
   logic                          fwd_ok, left_ok, right_ok;
   logic                          stay;
   logic [osr_pkg::FREQ_W-1:0]    ramp_step, ramp_max;
   logic [osr_pkg::FREQ_W:0]      ramp_sum;
   logic                          ramp_ok;
   osr_pkg::action_type           act;
   osr_pkg::drive_type            drive;

   always_comb begin
      front_sum   = {1'b0, sensor.dist_left_front} + {1'b0, sensor.dist_right_front};
      fwd_ok      = front_sum <= cfg.front_clear_limit;
      // right minus left, or left minus right, beyond the limit, compared without a signed subtract
      left_bound  = {1'b0, sensor.dist_left} + {1'b0, cfg.side_diff_limit};
      right_bound = {1'b0, sensor.dist_right} + {1'b0, cfg.side_diff_limit};
      left_ok     = {1'b0, sensor.dist_right} > left_bound;
      right_ok    = {1'b0, sensor.dist_left} > right_bound;

      case (mode_ff)
         osr_pkg::MODE_FWD:   stay = fwd_ok;
         osr_pkg::MODE_LEFT:  stay = left_ok;
         osr_pkg::MODE_RIGHT: stay = right_ok;
         default:             stay = 1'b0;
      endcase

      ramp_step = (mode_ff == osr_pkg::MODE_FWD) ? cfg.fwd_step : cfg.turn_step;
      ramp_max  = (mode_ff == osr_pkg::MODE_FWD) ? cfg.fwd_freq_limit : cfg.turn_freq_limit;
      ramp_sum  = {1'b0, freq_ff} + {1'b0, ramp_step};
      ramp_ok   = ramp_sum < {1'b0, ramp_max};

      if (stay) begin
         mode_in = mode_ff;
         if (ramp_ok) begin
            freq_in = ramp_sum[osr_pkg::FREQ_W-1:0];
            act     = osr_pkg::ACT_ACCEL;
         end else begin
            freq_in = freq_ff;
            act     = osr_pkg::ACT_HELD;
         end
      end else begin
         act = osr_pkg::ACT_CHANGED;
         if (fwd_ok) begin
            mode_in = osr_pkg::MODE_FWD;
            freq_in = cfg.fwd_base_freq;
         end else if (left_ok) begin
            mode_in = osr_pkg::MODE_LEFT;
            freq_in = cfg.turn_base_freq;
         end else if (right_ok) begin
            mode_in = osr_pkg::MODE_RIGHT;
            freq_in = cfg.turn_base_freq;
         end else begin
            mode_in = osr_pkg::MODE_BACK;
            freq_in = cfg.fwd_base_freq;
         end
      end

      case (mode_in)
         osr_pkg::MODE_FWD:   drive = osr_pkg::DRIVE_FWD;
         osr_pkg::MODE_LEFT:  drive = osr_pkg::DRIVE_LEFT;
         osr_pkg::MODE_RIGHT: drive = osr_pkg::DRIVE_RIGHT;
         default:             drive = osr_pkg::DRIVE_BACK;
      endcase

      result.drive_mode = drive;
      result.step_freq  = freq_in;
      result.action     = act;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= osr_pkg::MODE_IDLE;
         freq_ff <= '0;
      end else if (step_en) begin
         mode_ff <= mode_in;
         freq_ff <= freq_in;
      end
   end

endmodule

FILE: hdl/obstacle_steer_speed_ramp_top.sv
// Channel   Dir  Handshake           Word
// req_      in   req_valid/req_stall four distance readings
// rsp_      out  rsp_valid/rsp_stall drive mode, step frequency, action
// csr_      in   csr_valid/csr_ready register index, write data
//
// One sensor set per cycle sustained while rsp_stall stays low. An accepted
// word lands in the input register; the mode/frequency update then runs into
// the result register, which raises rsp_valid. Synchronous active-high reset
// restores the register defaults, idle mode and zero frequency. A stall on a
// valid rsp_ word freezes the result register and a full input register;
// req_stall rises only when the input register is full and cannot move on.
`include "obstacle_steer_speed_ramp_top_defines.svh"

module obstacle_steer_speed_ramp_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [osr_pkg::DIST_W-1:0]      req_dist_right,
   input  logic [osr_pkg::DIST_W-1:0]      req_dist_right_front,
   input  logic [osr_pkg::DIST_W-1:0]      req_dist_left_front,
   input  logic [osr_pkg::DIST_W-1:0]      req_dist_left,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_drive_mode,
   output logic [osr_pkg::FREQ_W-1:0]      rsp_step_freq,
   output logic [1:0]                      rsp_action,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [osr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [osr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   osr_pkg::cfg_type     cfg;
   osr_pkg::dist_type    dist_ff;
   osr_pkg::result_type  result, rsp_ff;
   logic                 in_valid_ff, rsp_valid_ff;
   logic                 out_adv, in_adv, step_en;

   assign out_adv = !rsp_valid_ff || !rsp_stall;
   assign in_adv  = !in_valid_ff || out_adv;
   assign step_en = in_valid_ff && out_adv;

   assign req_stall      = !in_adv;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_drive_mode = rsp_ff.drive_mode;
   assign rsp_step_freq  = rsp_ff.step_freq;
   assign rsp_action     = rsp_ff.action;

   osr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   osr_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .cfg     (cfg),
      .sensor  (dist_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_adv) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_adv && req_valid) begin
         dist_ff.dist_right       <= req_dist_right;
         dist_ff.dist_right_front <= req_dist_right_front;
         dist_ff.dist_left_front  <= req_dist_left_front;
         dist_ff.dist_left        <= req_dist_left;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   // capture the result only when the core commits its state update
   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_ff <= result;
      end
   end

   `OSR_ASSERT_NEXT(a_in_to_stage, clock, reset, req_valid && !req_stall, in_valid_ff)
   `OSR_ASSERT_NEXT(a_step_to_rsp, clock, reset, step_en, rsp_valid)
   `OSR_ASSERT_NOW(a_fwd_below_max, clock, reset,
      rsp_valid && rsp_action == osr_pkg::ACT_ACCEL && rsp_drive_mode == osr_pkg::DRIVE_FWD,
      rsp_step_freq < cfg.fwd_freq_limit)

endmodule

FILE: dv/obstacle_steer_speed_ramp_checker.sv
module obstacle_steer_speed_ramp_checker
   import osr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [DIST_W-1:0]      req_dist_right,
   input  logic [DIST_W-1:0]      req_dist_right_front,
   input  logic [DIST_W-1:0]      req_dist_left_front,
   input  logic [DIST_W-1:0]      req_dist_left,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [1:0]             rsp_drive_mode,
   input  logic [FREQ_W-1:0]      rsp_step_freq,
   input  logic [1:0]             rsp_action,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending,
   output int                     words_checked,
   output int                     changes_seen,
   output int                     ramps_seen,
   output int                     holds_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   cfg_type           regs;
   mode_type          steer_mode;
   logic [FREQ_W-1:0] steer_freq;
   result_type        expected_results[$];
   result_type        want;
   dist_type          sensed;

   initial begin
      fail_count    = 0;
      pending       = 0;
      words_checked = 0;
      changes_seen  = 0;
      ramps_seen    = 0;
      holds_seen    = 0;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      fail_count++;
   endtask

   function automatic action_type ramp_freq(input logic [FREQ_W-1:0] step,
                                            input logic [FREQ_W-1:0] freq_cap);
      logic [FREQ_W:0] next_freq;
      // compare at full width so the sum never wraps under the limit
      next_freq = {1'b0, steer_freq} + {1'b0, step};
      if (next_freq < {1'b0, freq_cap}) begin
         steer_freq = next_freq[FREQ_W-1:0];
         return ACT_ACCEL;
      end
      return ACT_HELD;
   endfunction

   function automatic result_type steer_update(input dist_type d);
      logic [FRONT_W-1:0] front_sum;
      int                 side_diff;
      bit                 fwd_ok;
      bit                 left_ok;
      bit                 right_ok;
      result_type         res;
      front_sum = FRONT_W'(d.dist_left_front) + FRONT_W'(d.dist_right_front);
      side_diff = int'(d.dist_right) - int'(d.dist_left);
      fwd_ok    = front_sum <= regs.front_clear_limit;
      left_ok   = side_diff > int'(regs.side_diff_limit);
      right_ok  = -side_diff > int'(regs.side_diff_limit);
      if (steer_mode == MODE_FWD && fwd_ok) begin
         res.action = ramp_freq(regs.fwd_step, regs.fwd_freq_limit);
      end else if (steer_mode == MODE_LEFT && left_ok) begin
         res.action = ramp_freq(regs.turn_step, regs.turn_freq_limit);
      end else if (steer_mode == MODE_RIGHT && right_ok) begin
         res.action = ramp_freq(regs.turn_step, regs.turn_freq_limit);
      end else begin
         // pick again by priority, even when it lands on the same mode
         res.action = ACT_CHANGED;
         if (fwd_ok) begin
            steer_mode = MODE_FWD;
            steer_freq = regs.fwd_base_freq;
         end else if (left_ok) begin
            steer_mode = MODE_LEFT;
            steer_freq = regs.turn_base_freq;
         end else if (right_ok) begin
            steer_mode = MODE_RIGHT;
            steer_freq = regs.turn_base_freq;
         end else begin
            steer_mode = MODE_BACK;
            steer_freq = regs.fwd_base_freq;
         end
      end
      case (steer_mode)
         MODE_FWD:   res.drive_mode = DRIVE_FWD;
         MODE_LEFT:  res.drive_mode = DRIVE_LEFT;
         MODE_RIGHT: res.drive_mode = DRIVE_RIGHT;
         default:    res.drive_mode = DRIVE_BACK;
      endcase
      res.step_freq = steer_freq;
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         regs.front_clear_limit = FRONT_CLEAR_RST;
         regs.side_diff_limit   = SIDE_DIFF_RST;
         regs.fwd_base_freq     = FWD_MIN_RST;
         regs.fwd_freq_limit    = FWD_MAX_RST;
         regs.fwd_step          = FWD_STEP_RST;
         regs.turn_base_freq    = TURN_MIN_RST;
         regs.turn_freq_limit   = TURN_MAX_RST;
         regs.turn_step         = TURN_STEP_RST;
         steer_mode = MODE_IDLE;
         steer_freq = '0;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (reg_index_type'(csr_index))
               REG_FRONT_CLEAR: regs.front_clear_limit = csr_wdata[FRONT_W-1:0];
               REG_SIDE_DIFF:   regs.side_diff_limit   = csr_wdata[SIDE_W-1:0];
               REG_FWD_MIN:     regs.fwd_base_freq     = csr_wdata;
               REG_FWD_MAX:     regs.fwd_freq_limit    = csr_wdata;
               REG_FWD_STEP:    regs.fwd_step          = csr_wdata;
               REG_TURN_MIN:    regs.turn_base_freq    = csr_wdata;
               REG_TURN_MAX:    regs.turn_freq_limit   = csr_wdata;
               REG_TURN_STEP:   regs.turn_step         = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            sensed.dist_right       = req_dist_right;
            sensed.dist_right_front = req_dist_right_front;
            sensed.dist_left_front  = req_dist_left_front;
            sensed.dist_left        = req_dist_left;
            expected_results.push_back(steer_update(sensed));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected word mode %0d freq %0d action %0d",
                                         rsp_drive_mode, rsp_step_freq, rsp_action));
            end else begin
               want = expected_results.pop_front();
               words_checked++;
               case (want.action)
                  ACT_CHANGED: changes_seen++;
                  ACT_ACCEL:   ramps_seen++;
                  default:     holds_seen++;
               endcase
               if (rsp_drive_mode !== want.drive_mode)
                  report_mismatch($sformatf("word %0d drive_mode got %0d want %0d",
                                            words_checked, rsp_drive_mode, want.drive_mode));
               if (rsp_step_freq !== want.step_freq)
                  report_mismatch($sformatf("word %0d step_freq got %0d want %0d",
                                            words_checked, rsp_step_freq, want.step_freq));
               if (rsp_action !== want.action)
                  report_mismatch($sformatf("word %0d action got %0d want %0d",
                                            words_checked, rsp_action, want.action));
            end
         end
      end
      pending = expected_results.size();
   end

endmodule

FILE: dv/tb_obstacle_steer_speed_ramp_top.sv
module tb_obstacle_steer_speed_ramp_top;
   import osr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 200;
   localparam int DRAIN_PAUSE = 4;
   localparam int MAX_DIST    = 4095;
   localparam int MAX_FRONT   = 8190;

   typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idling_type;
   typedef enum {WORD_FWD, WORD_LEFT, WORD_RIGHT, WORD_BACK, WORD_NOISE} word_kind_type;
   typedef enum {SIDE_LEFT, SIDE_RIGHT, SIDE_BAL} side_kind_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [DIST_W-1:0]     req_dist_right = '0;
   logic [DIST_W-1:0]     req_dist_right_front = '0;
   logic [DIST_W-1:0]     req_dist_left_front = '0;
   logic [DIST_W-1:0]     req_dist_left = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_drive_mode;
   logic [FREQ_W-1:0]     rsp_step_freq;
   logic [1:0]            rsp_action;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int fail_count;
   int pending;
   int words_checked;
   int changes_seen;
   int ramps_seen;
   int holds_seen;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   bit hold_request  = 1'b0;
   int hold_left     = 0;
   int front_lim     = int'(FRONT_CLEAR_RST);
   int side_lim      = int'(SIDE_DIFF_RST);
   int settings_used = 1;
   int quiet_cycles  = 0;

   always #5ns clock = ~clock;

   obstacle_steer_speed_ramp_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_dist_right       (req_dist_right),
      .req_dist_right_front (req_dist_right_front),
      .req_dist_left_front  (req_dist_left_front),
      .req_dist_left        (req_dist_left),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_drive_mode       (rsp_drive_mode),
      .rsp_step_freq        (rsp_step_freq),
      .rsp_action           (rsp_action),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   obstacle_steer_speed_ramp_checker checker_i (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_dist_right       (req_dist_right),
      .req_dist_right_front (req_dist_right_front),
      .req_dist_left_front  (req_dist_left_front),
      .req_dist_left        (req_dist_left),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_drive_mode       (rsp_drive_mode),
      .rsp_step_freq        (rsp_step_freq),
      .rsp_action           (rsp_action),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .fail_count           (fail_count),
      .pending              (pending),
      .words_checked        (words_checked),
      .changes_seen         (changes_seen),
      .ramps_seen           (ramps_seen),
      .holds_seen           (holds_seen)
   );

   // receiver: random stall, or a long hold-off when asked for one
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[%0t] no handshake for %0d cycles, %0d words pending",
                  $time, quiet_cycles, pending);
         $display("FAILURE");
         $finish;
      end
   end

   task automatic set_idling(input idling_type m);
      case (m)
         IDLE_NONE: begin send_idle_pct = 0;  stall_pct = 0;  end
         IDLE_SEND: begin send_idle_pct = 71; stall_pct = 0;  end
         IDLE_RECV: begin send_idle_pct = 0;  stall_pct = 71; end
         default:   begin send_idle_pct = 8;  stall_pct = 8;  end
      endcase
   endtask

   task automatic send_word(input dist_type d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_dist_right       <= d.dist_right;
      req_dist_right_front <= d.dist_right_front;
      req_dist_left_front  <= d.dist_left_front;
      req_dist_left        <= d.dist_left;
      do @(posedge clock); while (req_stall);
   endtask

   // drop valid, then let every expected word come back before touching registers
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [CSR_DATA_W-1:0] w);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= w;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_regs(input logic [15:0] w_front, w_side, w_fmin, w_fmax,
                               input logic [15:0] w_fstep, w_tmin, w_tmax, w_tstep);
      write_reg(REG_FRONT_CLEAR, w_front);
      write_reg(REG_SIDE_DIFF,   w_side);
      write_reg(REG_FWD_MIN,     w_fmin);
      write_reg(REG_FWD_MAX,     w_fmax);
      write_reg(REG_FWD_STEP,    w_fstep);
      write_reg(REG_TURN_MIN,    w_tmin);
      write_reg(REG_TURN_MAX,    w_tmax);
      write_reg(REG_TURN_STEP,   w_tstep);
      csr_valid <= 1'b0;
      front_lim = int'(w_front[FRONT_W-1:0]);
      side_lim  = int'(w_side[SIDE_W-1:0]);
      settings_used++;
   endtask

   function automatic dist_type make_dist(input int r, input int rf, input int lf,
                                          input int l);
      dist_type d;
      d.dist_right       = DIST_W'(r);
      d.dist_right_front = DIST_W'(rf);
      d.dist_left_front  = DIST_W'(lf);
      d.dist_left        = DIST_W'(l);
      return d;
   endfunction

   // front pair whose sum is at or below the limit (clear) or above it
   function automatic void pick_front(input bit clear, output int lf, output int rf);
      int lo;
      int hi;
      int s;
      if (clear) begin
         lo = 0;
         hi = (front_lim < MAX_FRONT) ? front_lim : MAX_FRONT;
      end else begin
         lo = (front_lim < MAX_FRONT) ? front_lim + 1 : MAX_FRONT;
         hi = MAX_FRONT;
      end
      if ($urandom_range(7) == 0)
         s = clear ? hi : lo;
      else
         s = $urandom_range(hi, lo);
      lf = $urandom_range((s < MAX_DIST) ? s : MAX_DIST, (s > MAX_DIST) ? s - MAX_DIST : 0);
      rf = s - lf;
   endfunction

   function automatic void pick_side(input side_kind_type k, output int r, output int l);
      int d;
      int m;
      if (k == SIDE_BAL) begin
         m = (side_lim < MAX_DIST) ? side_lim : MAX_DIST;
         d = ($urandom_range(7) == 0) ? m : $urandom_range(m);
         if ($urandom_range(1)) d = -d;
      end else begin
         m = (side_lim < MAX_DIST) ? side_lim + 1 : MAX_DIST;
         d = ($urandom_range(7) == 0) ? m : $urandom_range(MAX_DIST, m);
         if (k == SIDE_RIGHT) d = -d;
      end
      if (d >= 0) begin
         r = $urandom_range(MAX_DIST, d);
         l = r - d;
      end else begin
         l = $urandom_range(MAX_DIST, -d);
         r = l + d;
      end
   endfunction

   function automatic dist_type make_word(input word_kind_type kind);
      int r;
      int rf;
      int lf;
      int l;
      case (kind)
         WORD_FWD: begin
            pick_front(1'b1, lf, rf);
            r = $urandom_range(MAX_DIST);
            l = $urandom_range(MAX_DIST);
         end
         WORD_LEFT: begin
            pick_front(1'b0, lf, rf);
            pick_side(SIDE_LEFT, r, l);
         end
         WORD_RIGHT: begin
            pick_front(1'b0, lf, rf);
            pick_side(SIDE_RIGHT, r, l);
         end
         WORD_BACK: begin
            pick_front(1'b0, lf, rf);
            pick_side(SIDE_BAL, r, l);
         end
         default: begin
            r  = $urandom_range(MAX_DIST);
            rf = $urandom_range(MAX_DIST);
            lf = $urandom_range(MAX_DIST);
            l  = $urandom_range(MAX_DIST);
         end
      endcase
      return make_dist(r, rf, lf, l);
   endfunction

   // runs of one kind of reading so modes persist and ramp up to their limits
   task automatic random_run(input int count, input bit with_hold);
      int sent;
      int run_len;
      int pick;
      word_kind_type kind;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(9);
         if (pick < 4)       kind = WORD_FWD;
         else if (pick < 6)  kind = WORD_LEFT;
         else if (pick < 8)  kind = WORD_RIGHT;
         else if (pick == 8) kind = WORD_BACK;
         else                kind = WORD_NOISE;
         run_len = $urandom_range(24, 1);
         repeat (run_len) begin
            if (with_hold && sent == count / 4) hold_request = 1'b1;
            send_word(make_word(kind));
            sent++;
         end
      end
   endtask

   initial begin
      logic [15:0] fmin;
      logic [15:0] tmin;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults: each mode, priority order and the compare boundaries
      set_idling(IDLE_NONE);
      send_word(make_dist(0, 0, 0, 0));
      send_word(make_dist(0, 0, 0, 0));
      send_word(make_dist(0, 200, 200, 0));
      send_word(make_dist(0, 201, 200, 0));
      send_word(make_dist(0, 201, 200, 0));
      send_word(make_dist(11, 4095, 4095, 0));
      send_word(make_dist(4095, 4095, 4095, 0));
      send_word(make_dist(10, 4095, 4095, 0));
      send_word(make_dist(0, 4095, 4095, 11));
      send_word(make_dist(0, 4095, 4095, 4095));
      send_word(make_dist(4095, 4095, 4095, 4095));
      send_word(make_dist(4095, 0, 0, 0));
      send_word(make_dist(4095, 401, 0, 0));
      send_word(make_dist(0, 0, 0, 4095));
      random_run(200, 1'b1);
      drain();

      program_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                   16'h0000, 16'h0000, 16'h0000, 16'h0000);
      set_idling(IDLE_SEND);
      random_run(150, 1'b0);
      drain();

      // upper bits of the two narrow registers must be dropped
      program_regs(16'hFFFE, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      set_idling(IDLE_RECV);
      random_run(150, 1'b0);
      drain();

      // short ramps that hit the hold quickly
      program_regs(16'd3000, 16'd100, 16'd10, 16'd50, 16'd7, 16'd5, 16'd20, 16'd3);
      set_idling(IDLE_BOTH);
      repeat (8) send_word(make_dist(0, 0, 0, 0));
      random_run(200, 1'b0);
      drain();

      // ramp right under the top of the frequency range
      program_regs(16'd1000, 16'd50, 16'd65500, 16'd65535,
                   16'd20, 16'd65530, 16'd65535, 16'd2);
      set_idling(IDLE_NONE);
      random_run(100, 1'b0);
      drain();

      for (int k = 0; k < 3; k++) begin
         fmin = 16'($urandom_range(2000));
         tmin = 16'($urandom_range(2000));
         program_regs(16'($urandom_range(MAX_FRONT)),
                      16'($urandom_range(1) ? $urandom_range(600) : $urandom_range(MAX_DIST)),
                      fmin, fmin + 16'($urandom_range(3000)), 16'($urandom_range(300)),
                      tmin, tmin + 16'($urandom_range(1500)), 16'($urandom_range(200)));
         set_idling(idling_type'(k + 1));
         random_run(150, 1'b0);
         drain();
      end

      repeat (10) @(posedge clock);
      $display("covered %0d sensor words under %0d register settings", words_checked,
               settings_used);
      $display("mode picks %0d, ramp steps %0d, holds at limit %0d", changes_seen,
               ramps_seen, holds_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/osr_pkg.sv
hdl/osr_csr.sv
hdl/osr_core.sv
hdl/obstacle_steer_speed_ramp_top.sv
dv/obstacle_steer_speed_ramp_checker.sv
dv/tb_obstacle_steer_speed_ramp_top.sv
